// ----- rtl/word_count_hash_table_assert.svh -----
// assertion macros for the word count hash table checker
`ifndef WORD_COUNT_HASH_TABLE_ASSERT_SVH
`define WORD_COUNT_HASH_TABLE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define WCH_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);
// next-cycle implication
`define WCH_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);
`endif

// ----- rtl/wch_pkg.sv -----
// ----------------------------------------------------------------------------
// wch_pkg
// shared types and constants of the word count hash table
// ----------------------------------------------------------------------------
package wch_pkg;
  localparam int HashSlots    = 4096;
  localparam int VocabEntries = 1024;
  localparam int MaxWordBytes = 32;
  localparam int SlotW  = $clog2(HashSlots);
  localparam int EntW   = $clog2(VocabEntries);
  localparam int PosW   = $clog2(MaxWordBytes);
  localparam int LenW   = $clog2(MaxWordBytes + 1);
  localparam int UsedW  = $clog2(VocabEntries + 1);
  localparam int WordAW = EntW + PosW;
  localparam int SlotDW = EntW + 1;
  localparam int ProbeW = $clog2(HashSlots + 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_SLOT_RD, ST_SLOT_CHK, ST_LEN_RD,
    ST_CMP_RD, ST_CMP_CHK, ST_CNT_RD, ST_CNT_WR, ST_INS, ST_FAIL, ST_OUT
  } state_t;

  typedef struct packed {
    logic clr_step;     // clear one slot
    logic take_byte;
    logic fold_last;    // fold last buffered byte into hash
    logic slot_rd;
    logic probe_next;
    logic len_rd;
    logic cmp_start;
    logic cmp_rd;
    logic cmp_next;
    logic cnt_rd;
    logic cnt_wr;
    logic ins_step;     // copy one byte into entry store
    logic ins_commit;
    logic set_fail;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic slot_empty;
    logic len_match;
    logic byte_match;
    logic cmp_done;
    logic probe_wrap;
    logic vocab_full;
    logic ins_done;
  } sts_t;
endpackage

// ----- rtl/wch_if.sv -----
// ----------------------------------------------------------------------------
// wch_in_if / wch_out_if
// valid/ready channels for bytes in and counts out
// ----------------------------------------------------------------------------
interface wch_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       word_end;
  modport source (output valid, char_byte, word_end, input ready);
  modport sink (input valid, char_byte, word_end, output ready);
endinterface

interface wch_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  entry_index;
  logic [31:0] occurrences;
  logic        is_new;
  logic        status;
  modport source (output valid, entry_index, occurrences, is_new, status, input ready);
  modport sink (input valid, entry_index, occurrences, is_new, status, output ready);
endinterface

// ----- rtl/wch_ram.sv -----
// ----------------------------------------------------------------------------
// wch_ram
// single write port, single registered read port
// ----------------------------------------------------------------------------
module wch_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/wch_ctrl.sv -----
// ----------------------------------------------------------------------------
// wch_ctrl
// sequencer for clear, byte intake, probe, compare and update
// ----------------------------------------------------------------------------
module wch_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_end,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  wch_pkg::sts_t   sts,
  output wch_pkg::cmd_t   cmd
);
  wch_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wch_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wch_pkg::ST_CLEAR: if (sts.clr_done) state_next = wch_pkg::ST_IDLE;
      wch_pkg::ST_IDLE: if (in_valid && in_end) state_next = wch_pkg::ST_HASH;
      wch_pkg::ST_HASH: state_next = wch_pkg::ST_SLOT_RD;
      wch_pkg::ST_SLOT_RD: state_next = wch_pkg::ST_SLOT_CHK;
      wch_pkg::ST_SLOT_CHK: begin
        if (sts.slot_empty) begin
          state_next = sts.vocab_full ? wch_pkg::ST_FAIL : wch_pkg::ST_INS;
        end else begin
          state_next = wch_pkg::ST_LEN_RD;
        end
      end
      wch_pkg::ST_LEN_RD: state_next = wch_pkg::ST_CMP_RD;
      wch_pkg::ST_CMP_RD: begin
        if (!sts.len_match) begin
          state_next = sts.probe_wrap ? wch_pkg::ST_FAIL : wch_pkg::ST_SLOT_RD;
        end else begin
          state_next = wch_pkg::ST_CMP_CHK;
        end
      end
      wch_pkg::ST_CMP_CHK: begin
        if (!sts.byte_match) begin
          state_next = sts.probe_wrap ? wch_pkg::ST_FAIL : wch_pkg::ST_SLOT_RD;
        end else if (sts.cmp_done) begin
          state_next = wch_pkg::ST_CNT_RD;
        end
      end
      wch_pkg::ST_CNT_RD: state_next = wch_pkg::ST_CNT_WR;
      wch_pkg::ST_CNT_WR: state_next = wch_pkg::ST_OUT;
      wch_pkg::ST_INS: if (sts.ins_done) state_next = wch_pkg::ST_OUT;
      wch_pkg::ST_FAIL: state_next = wch_pkg::ST_OUT;
      wch_pkg::ST_OUT: if (out_ready) state_next = wch_pkg::ST_IDLE;
      default: state_next = wch_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      wch_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      wch_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
      end
      wch_pkg::ST_HASH: cmd.fold_last = 1'b1;
      wch_pkg::ST_SLOT_RD: cmd.slot_rd = 1'b1;
      wch_pkg::ST_SLOT_CHK: begin
        if (sts.slot_empty) begin
          cmd.set_fail = sts.vocab_full;
        end else begin
          cmd.len_rd = 1'b1;
        end
      end
      wch_pkg::ST_LEN_RD: cmd.cmp_start = 1'b1;
      wch_pkg::ST_CMP_RD: begin
        if (!sts.len_match) begin
          cmd.probe_next = 1'b1;
          cmd.set_fail   = sts.probe_wrap;
        end else begin
          cmd.cmp_rd = 1'b1;
        end
      end
      wch_pkg::ST_CMP_CHK: begin
        if (!sts.byte_match) begin
          cmd.probe_next = 1'b1;
          cmd.set_fail   = sts.probe_wrap;
        end else if (!sts.cmp_done) begin
          cmd.cmp_next = 1'b1;
          cmd.cmp_rd   = 1'b1;
        end
      end
      wch_pkg::ST_CNT_RD: cmd.cnt_rd = 1'b1;
      wch_pkg::ST_CNT_WR: cmd.cnt_wr = 1'b1;
      wch_pkg::ST_INS: begin
        cmd.ins_step   = 1'b1;
        cmd.ins_commit = sts.ins_done;
      end
      wch_pkg::ST_FAIL: cmd.out_load = 1'b1;
      wch_pkg::ST_OUT: out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

// ----- rtl/wch_datapath.sv -----
// ----------------------------------------------------------------------------
// wch_datapath
// hash, word buffer, slot table, entry stores and result register
// ----------------------------------------------------------------------------
module wch_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           char_byte,
  input  wch_pkg::cmd_t        cmd,
  output wch_pkg::sts_t        sts,
  output logic [9:0]           entry_index,
  output logic [31:0]          occurrences,
  output logic                 is_new,
  output logic                 status
);
  localparam int SlotW  = wch_pkg::SlotW;
  localparam int EntW   = wch_pkg::EntW;
  localparam int PosW   = wch_pkg::PosW;
  localparam int LenW   = wch_pkg::LenW;
  localparam int UsedW  = wch_pkg::UsedW;
  localparam int WordAW = wch_pkg::WordAW;
  localparam int SlotDW = wch_pkg::SlotDW;
  localparam int ProbeW = wch_pkg::ProbeW;

  logic [7:0]        word_buffer [wch_pkg::MaxWordBytes];
  logic [LenW-1:0]   word_length;
  logic [63:0]       running_hash;
  logic [UsedW-1:0]  entries_used;
  logic [SlotW-1:0]  slot;
  logic [ProbeW-1:0] probes;
  logic [SlotW-1:0]  clr_addr;
  logic [EntW-1:0]   cur_entry;
  logic [LenW-1:0]   cmp_pos;
  logic [PosW-1:0]   ins_pos;

  logic [SlotDW-1:0] slot_rdata, slot_wdata;
  logic [SlotW-1:0]  slot_waddr;
  logic              slot_we;
  logic [LenW-1:0]   len_rdata;
  logic [7:0]        word_rdata;
  logic [WordAW-1:0] word_raddr, word_waddr;
  logic [31:0]       cnt_rdata, cnt_wdata;
  logic              cnt_we;
  logic [EntW-1:0]   cnt_waddr;
  logic [EntW-1:0]   new_entry;
  logic [7:0]        last_byte;
  logic [63:0]       fold_val;

  assign new_entry = entries_used[EntW-1:0];
  assign last_byte = word_buffer[PosW'(word_length - LenW'(1))];
  assign fold_val  = running_hash * 64'd257 + {{56{last_byte[7]}}, last_byte};

  // byte intake and hash
  always_ff @(posedge clk) begin
    if (rst) begin
      word_length  <= '0;
      running_hash <= '0;
    end else if (cmd.take_byte) begin
      if (word_length < LenW'(wch_pkg::MaxWordBytes)) begin
        if (word_length != '0) running_hash <= fold_val;
        word_buffer[PosW'(word_length)] <= char_byte;
        word_length <= word_length + LenW'(1);
      end else begin
        word_buffer[wch_pkg::MaxWordBytes-1] <= char_byte;
      end
    end else if (cmd.fold_last) begin
      running_hash <= fold_val;
    end else if (cmd.out_load || cmd.ins_commit || cmd.cnt_wr) begin
      word_length  <= '0;
      running_hash <= '0;
    end
  end

  // probe position
  always_ff @(posedge clk) begin
    if (cmd.fold_last) begin
      slot   <= fold_val[SlotW-1:0];
      probes <= '0;
    end else if (cmd.probe_next) begin
      slot   <= slot + SlotW'(1);
      probes <= probes + ProbeW'(1);
    end
  end
  assign sts.probe_wrap = (probes == ProbeW'(wch_pkg::HashSlots - 1));

  // clearing pass over slot table
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + SlotW'(1);
    end
  end
  assign sts.clr_done = cmd.clr_step && (clr_addr == SlotW'(wch_pkg::HashSlots - 1));

  assign slot_we    = cmd.clr_step || cmd.ins_commit;
  assign slot_waddr = cmd.clr_step ? clr_addr : slot;
  assign slot_wdata = cmd.clr_step ? '0 : {1'b1, new_entry};

  wch_ram #(.Width(SlotDW), .Depth(wch_pkg::HashSlots)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot), .rdata(slot_rdata));

  assign sts.slot_empty = !slot_rdata[SlotDW-1];
  assign sts.vocab_full = (entries_used == UsedW'(wch_pkg::VocabEntries));

  always_ff @(posedge clk) begin
    if (cmd.len_rd) cur_entry <= slot_rdata[EntW-1:0];
  end

  wch_ram #(.Width(LenW), .Depth(wch_pkg::VocabEntries)) u_lens (
    .clk(clk), .we(cmd.ins_commit), .waddr(new_entry), .wdata(word_length),
    .raddr(slot_rdata[EntW-1:0]), .rdata(len_rdata));

  assign sts.len_match = (len_rdata == word_length);

  // byte compare, one byte per read
  always_ff @(posedge clk) begin
    if (cmd.cmp_start) begin
      cmp_pos <= '0;
    end else if (cmd.cmp_next) begin
      cmp_pos <= cmp_pos + LenW'(1);
    end
  end
  // the byte read back belongs to cmp_pos
  assign sts.cmp_done   = (cmp_pos + LenW'(1) >= word_length);
  assign word_raddr     = {cur_entry, PosW'(cmd.cmp_next ? cmp_pos + LenW'(1) : cmp_pos)};
  assign sts.byte_match = (word_rdata == word_buffer[PosW'(cmp_pos)]);

  // ins_pos walks the word, one byte per cycle
  always_ff @(posedge clk) begin
    if (rst || !cmd.ins_step) begin
      ins_pos <= '0;
    end else begin
      ins_pos <= ins_pos + PosW'(1);
    end
  end
  assign sts.ins_done = (LenW'(ins_pos) + LenW'(1) >= word_length);
  assign word_waddr   = {new_entry, ins_pos};

  wch_ram #(.Width(8), .Depth(wch_pkg::VocabEntries * wch_pkg::MaxWordBytes)) u_words (
    .clk(clk), .we(cmd.ins_step), .waddr(word_waddr), .wdata(word_buffer[ins_pos]),
    .raddr(word_raddr), .rdata(word_rdata));

  assign cnt_we    = cmd.cnt_wr || cmd.ins_commit;
  assign cnt_waddr = cmd.ins_commit ? new_entry : cur_entry;
  assign cnt_wdata = cmd.ins_commit ? 32'd1 :
                     ((cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 32'd1);

  wch_ram #(.Width(32), .Depth(wch_pkg::VocabEntries)) u_cnts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cur_entry), .rdata(cnt_rdata));

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
    end else if (cmd.ins_commit) begin
      entries_used <= entries_used + UsedW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_fail) begin
      entry_index <= '0;
      occurrences <= '0;
      is_new      <= 1'b0;
      status      <= 1'b1;
    end else if (cmd.cnt_wr) begin
      entry_index <= 10'(cur_entry);
      occurrences <= cnt_wdata;
      is_new      <= 1'b0;
      status      <= 1'b0;
    end else if (cmd.ins_commit) begin
      entry_index <= 10'(new_entry);
      occurrences <= 32'd1;
      is_new      <= 1'b1;
      status      <= 1'b0;
    end
  end
endmodule

// ----- rtl/word_count_hash_table.sv -----
// ----------------------------------------------------------------------------
// word_count_hash_table
// counts words streamed one byte at a time in a linear-probing hash table
// ----------------------------------------------------------------------------
// Input channel: one byte per transfer, word_end high on a word's final byte.
// Bytes that do not end a word are taken one per cycle.
// Output channel: one result per word: entry index, count after the update,
// new-word flag and a full status.
// Lookup, from the closing byte: the last byte is folded into the hash, then
// the first slot is read and checked; each occupied slot that does not match
// costs a length read and, if the lengths match, a compare of its bytes; after
// a match the count is read and written back, after an empty slot the word is
// copied byte by byte into the entry store unless the vocabulary is full, and
// then the result shows. The byte compare reads the entry store through its
// one read port.
// Throughput: one word at a time; the next byte is taken the cycle after the
// result is accepted.
// Reset: a clearing pass walks all 4096 slots, one per cycle, with the input
// held off; then the table is empty and the vocabulary has no entries.
// Stall: the result stays on the output until taken; no new byte is
// accepted until then.
// ----------------------------------------------------------------------------
module word_count_hash_table (
  input logic      clk,
  input logic      rst,
  wch_in_if.sink   in_ch,
  wch_out_if.source out_ch
);
  wch_pkg::cmd_t cmd;
  wch_pkg::sts_t sts;

  wch_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_end(in_ch.word_end),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd));

  wch_datapath u_dp (
    .clk(clk), .rst(rst), .char_byte(in_ch.char_byte), .cmd(cmd), .sts(sts),
    .entry_index(out_ch.entry_index), .occurrences(out_ch.occurrences),
    .is_new(out_ch.is_new), .status(out_ch.status));
endmodule

// ----- rtl/wch_checker.sv -----
// ----------------------------------------------------------------------------
// wch_checker
// port-level checks on the word count hash table
// ----------------------------------------------------------------------------
`include "word_count_hash_table_assert.svh"
module wch_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [31:0] occurrences,
  input logic       is_new,
  input logic       status
);
  `WCH_ASSERT_IMP(a_no_both, clk, rst, out_valid, !in_ready, "input open during result")
  `WCH_ASSERT_IMP(a_full_zero, clk, rst, out_valid && status, occurrences == 32'd0 && !is_new,
    "full result not zero")
  `WCH_ASSERT_IMP(a_new_one, clk, rst, out_valid && is_new, occurrences == 32'd1,
    "new word count not one")
  `WCH_ASSERT_NXT(a_end_busy, clk, rst, in_valid && in_ready && in_end, !in_ready,
    "byte taken during lookup")
  `WCH_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind word_count_hash_table wch_checker u_wch_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_end(in_ch.word_end), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .occurrences(out_ch.occurrences), .is_new(out_ch.is_new), .status(out_ch.status));
